### hw/rtl/efr_pkg.sv
// efr_pkg: shared constants, beat types and byte-wide crc-32 helper
// for the escaped frame receiver. no dependencies.
// used by the interfaces, the pipeline stages and the top level.
`default_nettype none

package efr_pkg;

    // framing bytes
    localparam logic [7:0] BYTE_STX = 8'hA2;
    localparam logic [7:0] BYTE_ETX = 8'hA3;
    localparam logic [7:0] BYTE_ATX = 8'hA4;
    localparam logic [7:0] BYTE_ESC = 8'hAA;

    // codes that follow an escape
    localparam logic [7:0] CODE_STX = 8'h02;
    localparam logic [7:0] CODE_ETX = 8'h03;
    localparam logic [7:0] CODE_ATX = 8'h04;
    localparam logic [7:0] CODE_ESC = 8'h0A;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    typedef logic [1:0] kind_t;
    localparam kind_t K_PAYLOAD = 2'd0;
    localparam kind_t K_OK      = 2'd1;
    localparam kind_t K_BADCRC  = 2'd2;
    localparam kind_t K_ABORT   = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       timeout_event;
    } rx_beat_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic       last;
    } res_beat_t;

    // reflected crc-32, one byte per call
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // msb: code was valid, low byte: decoded value
    function automatic logic [8:0] unescape(input logic [7:0] code);
        logic [8:0] r;
        r = 9'd0;
        if (code == CODE_STX) begin
            r = {1'b1, BYTE_STX};
        end else if (code == CODE_ETX) begin
            r = {1'b1, BYTE_ETX};
        end else if (code == CODE_ATX) begin
            r = {1'b1, BYTE_ATX};
        end else if (code == CODE_ESC) begin
            r = {1'b1, BYTE_ESC};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/efr_ifs.sv
// efr interfaces: receive byte channel, result channel and config write
// channel, each a valid/ready handshake. depends on efr_pkg.
`default_nettype none

interface efr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       timeout_event;

    modport source (output valid, output rx_byte, output timeout_event, input ready);
    modport sink   (input valid, input rx_byte, input timeout_event, output ready);
endinterface

interface efr_res_if;
    logic             valid;
    logic             ready;
    efr_pkg::kind_t   kind;
    logic [7:0]       payload_byte;
    logic             last;

    modport source (output valid, output kind, output payload_byte, output last,
                    input ready);
    modport sink   (input valid, input kind, input payload_byte, input last,
                    output ready);
endinterface

interface efr_cfg_if;
    logic valid;
    logic ready;
    logic crc_check_enable;

    modport source (output valid, output crc_check_enable, input ready);
    modport sink   (input valid, input crc_check_enable, output ready);
endinterface

`default_nettype wire

### hw/rtl/efr_in_stage.sv
// efr_in_stage: input register for receive beats.
// depends on efr_pkg.
`default_nettype none

module efr_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire efr_pkg::rx_beat_t in_beat,
    input  wire logic              take,
    output logic                   hold_valid,
    output efr_pkg::rx_beat_t      hold_beat
);

    logic              valid_reg;
    logic              valid_next;
    efr_pkg::rx_beat_t beat_reg;

    // refill in the same cycle the held beat moves on
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= in_beat;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_beat  = beat_reg;

endmodule

`default_nettype wire

### hw/rtl/efr_deframer.sv
// efr_deframer: frame state, escape decode and crc-32 check for one beat.
// state advances when fire is high. depends on efr_pkg.
`default_nettype none

module efr_deframer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire efr_pkg::rx_beat_t beat,
    input  wire logic              crc_check_enable,
    output logic                   res_valid,
    output efr_pkg::res_beat_t     res_beat
);

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_CRC  = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  prev_reg, prev_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rcv_reg, rcv_next;
    logic [1:0]  cnt_reg, cnt_next;

    logic           open_frame;
    logic           esc;
    logic [7:0]     b;
    logic [31:0]    crc_fed;
    logic [8:0]     unesc;
    logic [7:0]     crc_val;
    logic [31:0]    rcv_shift;
    efr_pkg::kind_t kind;
    logic [7:0]     pay;

    assign b          = beat.rx_byte;
    assign open_frame = (phase_reg == PH_BODY) || (phase_reg == PH_CRC);
    assign esc        = (prev_reg == efr_pkg::BYTE_ESC);
    assign crc_fed    = efr_pkg::crc32_byte(crc_reg, b);
    assign unesc      = efr_pkg::unescape(b);
    assign crc_val    = esc ? unesc[7:0] : b;
    assign rcv_shift  = {rcv_reg[23:0], crc_val};

    always_comb
    begin
        phase_next = phase_reg;
        prev_next  = prev_reg;
        crc_next   = crc_reg;
        rcv_next   = rcv_reg;
        cnt_next   = cnt_reg;
        res_valid  = 1'b0;
        kind       = efr_pkg::K_PAYLOAD;
        pay        = 8'd0;

        priority if (beat.timeout_event)
        begin
            phase_next = PH_WAIT;
            rcv_next   = 32'd0;
            cnt_next   = 2'd0;
            prev_next  = 8'd0;
            crc_next   = efr_pkg::CRC_INIT;
            res_valid  = open_frame;
            kind       = efr_pkg::K_ABORT;
        end
        else if (b == efr_pkg::BYTE_STX)
        begin
            phase_next = PH_BODY;
            crc_next   = efr_pkg::CRC_INIT;
            rcv_next   = 32'd0;
            cnt_next   = 2'd0;
            prev_next  = b;
            res_valid  = open_frame;
            kind       = efr_pkg::K_ABORT;
        end
        else if (b == efr_pkg::BYTE_ATX)
        begin
            phase_next = PH_WAIT;
            rcv_next   = 32'd0;
            cnt_next   = 2'd0;
            prev_next  = b;
            res_valid  = open_frame;
            kind       = efr_pkg::K_ABORT;
        end
        else if (phase_reg == PH_BODY)
        begin
            if (b == efr_pkg::BYTE_ETX)
            begin
                // close byte: prev byte left as is unless it ends an escape
                rcv_next = 32'd0;
                cnt_next = 2'd0;
                if (esc)
                begin
                    phase_next = PH_WAIT;
                    prev_next  = b;
                    res_valid  = 1'b1;
                    kind       = efr_pkg::K_ABORT;
                end
                else if (crc_check_enable)
                begin
                    phase_next = PH_CRC;
                end
                else
                begin
                    phase_next = PH_WAIT;
                    res_valid  = 1'b1;
                    kind       = efr_pkg::K_OK;
                end
            end
            else
            begin
                crc_next  = crc_fed;
                prev_next = b;
                if (esc)
                begin
                    res_valid = 1'b1;
                    if (!unesc[8])
                    begin
                        phase_next = PH_WAIT;
                        rcv_next   = 32'd0;
                        cnt_next   = 2'd0;
                        kind       = efr_pkg::K_ABORT;
                    end
                    else
                    begin
                        pay = unesc[7:0];
                    end
                end
                else if (b != efr_pkg::BYTE_ESC)
                begin
                    res_valid = 1'b1;
                    pay       = b;
                end
            end
        end
        else if (phase_reg == PH_CRC)
        begin
            prev_next = b;
            if (esc && !unesc[8])
            begin
                phase_next = PH_WAIT;
                rcv_next   = 32'd0;
                cnt_next   = 2'd0;
                res_valid  = 1'b1;
                kind       = efr_pkg::K_ABORT;
            end
            else if (esc || b != efr_pkg::BYTE_ESC)
            begin
                if (cnt_reg == 2'd3)
                begin
                    // fourth crc byte completes the big-endian word
                    phase_next = PH_WAIT;
                    rcv_next   = 32'd0;
                    cnt_next   = 2'd0;
                    res_valid  = 1'b1;
                    kind       = ((~crc_reg) == rcv_shift) ? efr_pkg::K_OK
                                                           : efr_pkg::K_BADCRC;
                end
                else
                begin
                    rcv_next = rcv_shift;
                    cnt_next = cnt_reg + 2'd1;
                end
            end
        end
        else
        begin
            phase_next = PH_WAIT;
            prev_next  = b;
        end
    end

    assign res_beat.kind         = kind;
    assign res_beat.payload_byte = (kind == efr_pkg::K_PAYLOAD) ? pay : 8'd0;
    assign res_beat.last         = (kind != efr_pkg::K_PAYLOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            prev_reg  <= 8'd0;
            crc_reg   <= efr_pkg::CRC_INIT;
            rcv_reg   <= 32'd0;
            cnt_reg   <= 2'd0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            crc_reg   <= crc_next;
            rcv_reg   <= rcv_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/efr_out_stage.sv
// efr_out_stage: result register in front of the result channel.
// depends on efr_pkg.
`default_nettype none

module efr_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire efr_pkg::res_beat_t load_beat,
    output logic                    free,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output efr_pkg::res_beat_t      out_beat
);

    logic               valid_reg;
    logic               valid_next;
    efr_pkg::res_beat_t beat_reg;

    // a new result may land in the cycle the old one is taken
    assign free       = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= load_beat;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

`default_nettype wire

### hw/rtl/escaped_frame_receiver_crc32_core.sv
// escaped_frame_receiver_crc32_core: byte-stuffing deframer with crc-32 check.
// depends on efr_pkg, efr_ifs, efr_in_stage, efr_deframer, efr_out_stage.
//
//  channel  modport  payload                          beat moves when
//  rx       sink     rx_byte, timeout_event           rx.valid & rx.ready
//  frame    source   kind, payload_byte, last         frame.valid & frame.ready
//  cfg      sink     crc_check_enable                 cfg.valid & cfg.ready
//
// one byte per cycle sustained while the result channel takes beats; a byte is
// first taken into the input register, and its result, if it has one, is then
// loaded into the result register, from which the result beat leaves.
// the crc-32 byte update and escape decode sit between those two registers.
// rst_n (async, low) sends the block to wait-for-start with crc check enabled.
// a stalled result register holds the decode stage, which in turn lowers rx.ready
// once the input register is full; cfg is always ready.
`default_nettype none

module escaped_frame_receiver_crc32_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    efr_rx_if.sink     rx,
    efr_res_if.source  frame,
    efr_cfg_if.sink    cfg
);

    logic               crc_en_reg;
    logic               hold_valid;
    efr_pkg::rx_beat_t  rx_beat;
    efr_pkg::rx_beat_t  hold_beat;
    logic               out_free;
    logic               fire;
    logic               res_valid;
    efr_pkg::res_beat_t res_beat;
    efr_pkg::res_beat_t out_beat;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_en_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            crc_en_reg <= cfg.crc_check_enable;
        end
    end

    assign rx_beat.rx_byte       = rx.rx_byte;
    assign rx_beat.timeout_event = rx.timeout_event;

    efr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rx.valid),
        .in_ready   (rx.ready),
        .in_beat    (rx_beat),
        .take       (fire),
        .hold_valid (hold_valid),
        .hold_beat  (hold_beat)
    );

    assign fire = hold_valid && out_free;

    efr_deframer u_deframer (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (fire),
        .beat             (hold_beat),
        .crc_check_enable (crc_en_reg),
        .res_valid        (res_valid),
        .res_beat         (res_beat)
    );

    efr_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && res_valid),
        .load_beat (res_beat),
        .free      (out_free),
        .out_valid (frame.valid),
        .out_ready (frame.ready),
        .out_beat  (out_beat)
    );

    assign frame.kind         = out_beat.kind;
    assign frame.payload_byte = out_beat.payload_byte;
    assign frame.last         = out_beat.last;

endmodule

`default_nettype wire
